>>> rtl/primitive_hit_test_unit_assert.svh
// assertion macros shared by the hit test unit
`ifndef PRIMITIVE_HIT_TEST_UNIT_ASSERT_SVH
`define PRIMITIVE_HIT_TEST_UNIT_ASSERT_SVH
// same-cycle implication
`define PHTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phtu assertion failed");
// next-cycle implication
`define PHTU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phtu assertion failed");
`endif

>>> rtl/phtu_pkg.sv
// types and constants of the primitive hit test unit
`default_nettype none
package phtu_pkg;
    localparam int TOL_BITS      = 23;
    localparam int TSQ_BITS      = 2 * TOL_BITS;
    localparam int T4SQ_BITS     = TSQ_BITS + 2;
    // tp, ts, r+t and |r-t| carried with each item
    localparam int ITEM_TOL_BITS = 2 * TOL_BITS + 2 * (TOL_BITS + 1);

    typedef enum logic [1:0] {
        ACT_POINT   = 2'd0,
        ACT_CIRCLE  = 2'd1,
        ACT_SEGMENT = 2'd2,
        ACT_ARC     = 2'd3
    } t_action;

    typedef enum logic {
        CFG_TOL_POINT   = 1'b0,
        CFG_TOL_SEGMENT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic is_point;
        logic is_circle;
        logic is_segment;
        logic is_arc;
        logic r_gt_t;
    } t_kind;

    typedef struct packed {
        logic is_point;
        logic is_circle;
        logic is_segment;
        logic is_arc;
        logic pt_hit;
        logic circ_hit;
        logic seg_wide;
        logic seg_early;
        logic ang_ok;
        logic le1;
        logic le2;
    } t_flags;
endpackage
`default_nettype wire

>>> rtl/primitive_hit_test_unit.sv
// one result per item
// throughput: one item per cycle unless the output stalls; the back end is a stalling pipeline
// of six stages plus the output register, set by the two-stage split wide multipliers
// a two-entry queue decouples the front register from the back pipeline
// reset: synchronous active low, clears valid bits and the queue, tolerances to 3.0 and 5.0
`default_nettype none
module primitive_hit_test_unit #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic                                  i_cfg_idx,
    input  wire logic [phtu_pkg::TOL_BITS-1:0]         i_cfg_data,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // cursor_x, cursor_y, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, circle_radius, zero fill
    input  wire logic [((8*COORD_BITS+phtu_pkg::TOL_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // action
    input  wire logic [1:0]                            i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // hit, zero fill
    output logic [7:0]                                 o_m_axis_tdata
);
    localparam int W    = COORD_BITS;
    localparam int IW   = 6 * (W + 1) + phtu_pkg::ITEM_TOL_BITS;
    localparam int KW   = $bits(phtu_pkg::t_kind);
    localparam int QW   = IW + KW;
    localparam int RAD0 = 8 * W;

    logic            f_valid, f_ready, q_valid, q_pop, b_hit;
    phtu_pkg::t_kind f_kind;
    logic [IW-1:0]   f_item;
    logic [QW-1:0]   q_data;

    phtu_front #(.COORD_BITS(W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_action  (i_s_axis_tuser),
        .i_cx      (i_s_axis_tdata[0*W +: W]),
        .i_cy      (i_s_axis_tdata[1*W +: W]),
        .i_p0x     (i_s_axis_tdata[2*W +: W]),
        .i_p0y     (i_s_axis_tdata[3*W +: W]),
        .i_p1x     (i_s_axis_tdata[4*W +: W]),
        .i_p1y     (i_s_axis_tdata[5*W +: W]),
        .i_p2x     (i_s_axis_tdata[6*W +: W]),
        .i_p2y     (i_s_axis_tdata[7*W +: W]),
        .i_radius  (i_s_axis_tdata[RAD0 +: phtu_pkg::TOL_BITS]),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_kind    (f_kind),
        .o_item    (f_item)
    );

    phtu_fifo #(.DATA_BITS(QW), .DEPTH(2)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_data ({f_kind, f_item}),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_data (q_data)
    );

    phtu_back #(.COORD_BITS(W)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_pop  (q_pop),
        .i_kind (phtu_pkg::t_kind'(q_data[QW-1:IW])),
        .i_item (q_data[IW-1:0]),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_hit  (b_hit)
    );

    assign o_m_axis_tdata = {7'b0, b_hit};
endmodule
`default_nettype wire

>>> rtl/phtu_front.sv
// front end: tolerance registers, classification and difference vectors
`default_nettype none
module phtu_front #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_we,
    input  wire logic                                    i_cfg_idx,
    input  wire logic [phtu_pkg::TOL_BITS-1:0]           i_cfg_data,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic [1:0]                              i_action,
    input  wire logic signed [COORD_BITS-1:0]            i_cx,
    input  wire logic signed [COORD_BITS-1:0]            i_cy,
    input  wire logic signed [COORD_BITS-1:0]            i_p0x,
    input  wire logic signed [COORD_BITS-1:0]            i_p0y,
    input  wire logic signed [COORD_BITS-1:0]            i_p1x,
    input  wire logic signed [COORD_BITS-1:0]            i_p1y,
    input  wire logic signed [COORD_BITS-1:0]            i_p2x,
    input  wire logic signed [COORD_BITS-1:0]            i_p2y,
    input  wire logic [phtu_pkg::TOL_BITS-1:0]           i_radius,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output phtu_pkg::t_kind                              o_kind,
    output logic [6*(COORD_BITS+1)+phtu_pkg::ITEM_TOL_BITS-1:0] o_item
);
    localparam int D  = COORD_BITS + 1;
    localparam int TB = phtu_pkg::TOL_BITS;

    typedef struct packed {
        logic signed [D-1:0] v0x;
        logic signed [D-1:0] v0y;
        logic signed [D-1:0] v1x;
        logic signed [D-1:0] v1y;
        logic signed [D-1:0] v2x;
        logic signed [D-1:0] v2y;
        logic [TB-1:0]       tp;
        logic [TB-1:0]       ts;
        logic [TB:0]         rpt;
        logic [TB:0]         rmt;
    } t_item;

    logic [TB-1:0]       r_tol_point;
    logic [TB-1:0]       r_tol_seg;
    logic                r_valid;
    phtu_pkg::t_kind     r_kind;
    t_item               r_item;
    phtu_pkg::t_kind     n_kind;
    t_item               n_item;

    logic signed [D-1:0] e_cx, e_cy, e_p0x, e_p0y, e_p1x, e_p1y, e_p2x, e_p2y;

    assign e_cx  = D'(i_cx);
    assign e_cy  = D'(i_cy);
    assign e_p0x = D'(i_p0x);
    assign e_p0y = D'(i_p0y);
    assign e_p1x = D'(i_p1x);
    assign e_p1y = D'(i_p1y);
    assign e_p2x = D'(i_p2x);
    assign e_p2y = D'(i_p2y);

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_point <= TB'(768);
            r_tol_seg   <= TB'(1280);
        end else if (i_cfg_we) begin
            case (phtu_pkg::t_cfg_idx'(i_cfg_idx))
                phtu_pkg::CFG_TOL_POINT:   r_tol_point <= i_cfg_data;
                phtu_pkg::CFG_TOL_SEGMENT: r_tol_seg   <= i_cfg_data;
                default:                   r_tol_point <= r_tol_point;
            endcase
        end
    end

    always_comb begin
        n_kind      = '0;
        n_item.v0x  = e_cx - e_p0x;
        n_item.v0y  = e_cy - e_p0y;
        n_item.v1x  = e_p1x - e_p0x;
        n_item.v1y  = e_p1y - e_p0y;
        n_item.v2x  = e_cx - e_p1x;
        n_item.v2y  = e_cy - e_p1y;
        n_item.tp   = r_tol_point;
        n_item.ts   = r_tol_seg;
        n_item.rpt  = {1'b0, i_radius} + {1'b0, r_tol_point};
        n_item.rmt  = (i_radius > r_tol_point) ? {1'b0, i_radius - r_tol_point}
                                               : {1'b0, r_tol_point - i_radius};
        n_kind.r_gt_t = i_radius > r_tol_point;
        case (phtu_pkg::t_action'(i_action))
            phtu_pkg::ACT_POINT:   n_kind.is_point   = 1'b1;
            phtu_pkg::ACT_CIRCLE:  n_kind.is_circle  = 1'b1;
            phtu_pkg::ACT_SEGMENT: n_kind.is_segment = 1'b1;
            phtu_pkg::ACT_ARC: begin
                // cursor, end and start relative to the center, y pointing up
                n_kind.is_arc = 1'b1;
                n_item.v0x    = e_cx - e_p2x;
                n_item.v0y    = e_p2y - e_cy;
                n_item.v1x    = e_p1x - e_p2x;
                n_item.v1y    = e_p2y - e_p1y;
                n_item.v2x    = e_p0x - e_p2x;
                n_item.v2y    = e_p2y - e_p0y;
            end
            default: n_kind.is_point = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= n_kind;
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

>>> rtl/phtu_fifo.sv
// short queue between front and back end
`default_nettype none
`include "primitive_hit_test_unit_assert.svh"
module phtu_fifo #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [DATA_BITS-1:0] i_data,
    output logic                      o_valid,
    input  wire logic                 i_pop,
    output logic [DATA_BITS-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_wptr;
    logic [AW-1:0]        r_rptr;
    logic [CW-1:0]        r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_valid = r_count != '0;
    assign w_pop   = i_pop && o_valid;
    assign o_ready = (r_count != CW'(DEPTH)) || w_pop;
    assign w_push  = i_valid && o_ready;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `PHTU_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `PHTU_ASSERT_NXT(a_count_inc, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + CW'(1))
    `PHTU_ASSERT_NXT(a_count_dec, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - CW'(1))
    `PHTU_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wptr == r_rptr)
endmodule
`default_nettype wire

>>> rtl/phtu_mul.sv
// two-stage unsigned multiplier built from four half-width partial products
`default_nettype none
module phtu_mul #(
    parameter int A_BITS = 32,
    parameter int B_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [A_BITS-1:0]        i_a,
    input  wire logic [B_BITS-1:0]        i_b,
    output logic [A_BITS+B_BITS-1:0]      o_p
);
    localparam int AL = A_BITS / 2;
    localparam int AH = A_BITS - AL;
    localparam int BL = B_BITS / 2;
    localparam int BH = B_BITS - BL;
    localparam int PW = A_BITS + B_BITS;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    assign o_p = r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0] * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0] * i_b[B_BITS-1:BL];
            r_hl <= i_a[A_BITS-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[A_BITS-1:AL] * i_b[B_BITS-1:BL];
            r_p  <= PW'(r_ll) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
                  + (PW'(r_hh) << (AL + BL));
        end
    end
endmodule
`default_nettype wire

>>> rtl/phtu_back.sv
// back end: products, distance and sector tests, wide squared compares
`default_nettype none
module phtu_back #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_pop,
    input  wire phtu_pkg::t_kind                         i_kind,
    input  wire logic [6*(COORD_BITS+1)+phtu_pkg::ITEM_TOL_BITS-1:0] i_item,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic                                         o_hit
);
    localparam int D   = COORD_BITS + 1;
    localparam int TB  = phtu_pkg::TOL_BITS;
    localparam int T2  = phtu_pkg::TSQ_BITS;
    localparam int T4  = phtu_pkg::T4SQ_BITS;
    localparam int LW  = 2 * D;
    localparam int CW  = LW + 1;
    localparam int RW  = 2 * (TB + 1);
    localparam int XW  = (LW > T4) ? LW : T4;
    localparam int LMW = XW + 1;
    localparam int P0W = 2 * LMW;
    localparam int P1W = LW + T4;
    localparam int PXW = (P0W > P1W) ? P0W : P1W;

    typedef struct packed {
        logic signed [D-1:0] v0x;
        logic signed [D-1:0] v0y;
        logic signed [D-1:0] v1x;
        logic signed [D-1:0] v1y;
        logic signed [D-1:0] v2x;
        logic signed [D-1:0] v2y;
        logic [TB-1:0]       tp;
        logic [TB-1:0]       ts;
        logic [TB:0]         rpt;
        logic [TB:0]         rmt;
    } t_item;

    function automatic logic half_of(logic signed [D-1:0] x, logic signed [D-1:0] y);
        logic y_pos;
        y_pos = !y[D-1] && (y != '0);
        return !(y_pos || ((y == '0) && !x[D-1]));
    endfunction

    function automatic logic pos(logic signed [CW-1:0] v);
        return !v[CW-1] && (v != '0);
    endfunction

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_out_valid;
    logic r_hit;

    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = w_en;
    assign o_valid = r_out_valid;
    assign o_hit   = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_out_valid <= r_v6;
        end
    end

    // stage 1: component products
    t_item               w_it;
    logic signed [D-1:0] f0x, f0y, f1x, f1y, f2x, f2y;
    logic                z0, z1, z2, is_arc;

    assign w_it   = i_item;
    assign is_arc = i_kind.is_arc;
    assign z0     = (w_it.v0x == '0) && (w_it.v0y == '0);
    assign z1     = (w_it.v1x == '0) && (w_it.v1y == '0);
    assign z2     = (w_it.v2x == '0) && (w_it.v2y == '0);
    // a direction of zero length counts as angle zero
    assign f0x    = (is_arc && z0) ? D'(1) : w_it.v0x;
    assign f1x    = (is_arc && z1) ? D'(1) : w_it.v1x;
    assign f2x    = (is_arc && z2) ? D'(1) : w_it.v2x;
    assign f0y    = w_it.v0y;
    assign f1y    = w_it.v1y;
    assign f2y    = w_it.v2y;

    phtu_pkg::t_kind      r1_kind;
    logic                 r1_zseg, r1_hq, r1_ha, r1_hb;
    logic signed [LW-1:0] r1_s0x, r1_s0y, r1_s1x, r1_s1y, r1_s2x, r1_s2y;
    logic signed [LW-1:0] r1_du_a, r1_du_b, r1_df_a, r1_df_b;
    logic signed [LW-1:0] r1_qa_a, r1_qa_b, r1_ba_a, r1_ba_b, r1_bq_a, r1_bq_b;
    logic [T2-1:0]        r1_tp2, r1_ts2;
    logic [RW-1:0]        r1_rp2, r1_rm2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_kind <= i_kind;
            r1_zseg <= z1;
            r1_hq   <= half_of(f0x, f0y);
            r1_ha   <= half_of(f1x, f1y);
            r1_hb   <= half_of(f2x, f2y);
            r1_s0x  <= w_it.v0x * w_it.v0x;
            r1_s0y  <= w_it.v0y * w_it.v0y;
            r1_s1x  <= w_it.v1x * w_it.v1x;
            r1_s1y  <= w_it.v1y * w_it.v1y;
            r1_s2x  <= w_it.v2x * w_it.v2x;
            r1_s2y  <= w_it.v2y * w_it.v2y;
            r1_du_a <= w_it.v0x * w_it.v1x;
            r1_du_b <= w_it.v0y * w_it.v1y;
            r1_df_a <= w_it.v2x * w_it.v1x;
            r1_df_b <= w_it.v2y * w_it.v1y;
            r1_qa_a <= f0x * f1y;
            r1_qa_b <= f0y * f1x;
            r1_ba_a <= f2x * f1y;
            r1_ba_b <= f2y * f1x;
            r1_bq_a <= f2x * f0y;
            r1_bq_b <= f2y * f0x;
            r1_tp2  <= w_it.tp * w_it.tp;
            r1_ts2  <= w_it.ts * w_it.ts;
            r1_rp2  <= w_it.rpt * w_it.rpt;
            r1_rm2  <= w_it.rmt * w_it.rmt;
        end
    end

    // stage 2: squared lengths, dot and cross sums
    phtu_pkg::t_kind      r2_kind;
    logic                 r2_zseg, r2_hq, r2_ha, r2_hb;
    logic [LW-1:0]        r2_l0, r2_l1, r2_l2;
    logic signed [CW-1:0] r2_du, r2_df, r2_qa, r2_ba, r2_bq;
    logic [T2-1:0]        r2_tp2, r2_ts2;
    logic [RW-1:0]        r2_rp2, r2_rm2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_kind <= r1_kind;
            r2_zseg <= r1_zseg;
            r2_hq   <= r1_hq;
            r2_ha   <= r1_ha;
            r2_hb   <= r1_hb;
            r2_l0   <= $unsigned(r1_s0x) + $unsigned(r1_s0y);
            r2_l1   <= $unsigned(r1_s1x) + $unsigned(r1_s1y);
            r2_l2   <= $unsigned(r1_s2x) + $unsigned(r1_s2y);
            r2_du   <= CW'(r1_du_a) + CW'(r1_du_b);
            r2_df   <= CW'(r1_df_a) + CW'(r1_df_b);
            r2_qa   <= CW'(r1_qa_a) - CW'(r1_qa_b);
            r2_ba   <= CW'(r1_ba_a) - CW'(r1_ba_b);
            r2_bq   <= CW'(r1_bq_a) - CW'(r1_bq_b);
            r2_tp2  <= r1_tp2;
            r2_ts2  <= r1_ts2;
            r2_rp2  <= r1_rp2;
            r2_rm2  <= r1_rm2;
        end
    end

    // stage 3: narrow decisions, ring limits, cross magnitude
    phtu_pkg::t_flags w3_f;
    logic             lt_ba, lt_qa, lt_bq, seg_start, seg_end;
    logic [XW-1:0]    x_l0, x_l2, x_tp2, x_ts2;

    assign x_l0  = XW'(r2_l0);
    assign x_l2  = XW'(r2_l2);
    assign x_tp2 = XW'(r2_tp2);
    assign x_ts2 = XW'(r2_ts2);
    assign lt_ba = (r2_hb != r2_ha) ? (!r2_hb && r2_ha) : pos(r2_ba);
    assign lt_qa = (r2_hq != r2_ha) ? (!r2_hq && r2_ha) : pos(r2_qa);
    assign lt_bq = (r2_hb != r2_hq) ? (!r2_hb && r2_hq) : pos(r2_bq);
    // projection falls before the start or past the end of the segment
    assign seg_start = r2_zseg || r2_du[CW-1] || (r2_du == '0);
    assign seg_end   = !r2_df[CW-1];

    always_comb begin
        w3_f            = '0;
        w3_f.is_point   = r2_kind.is_point;
        w3_f.is_circle  = r2_kind.is_circle;
        w3_f.is_segment = r2_kind.is_segment;
        w3_f.is_arc     = r2_kind.is_arc;
        w3_f.pt_hit     = x_l0 <= x_tp2;
        w3_f.circ_hit   = (x_l0 <= XW'(r2_rp2)) && (!r2_kind.r_gt_t || (XW'(r2_rm2) <= x_l0));
        w3_f.seg_wide   = !seg_start && !seg_end;
        w3_f.seg_early  = seg_start ? (x_l0 <= x_ts2) : (x_l2 <= x_ts2);
        w3_f.ang_ok     = lt_ba ? (!lt_qa || !lt_bq) : (!lt_qa && !lt_bq);
    end

    phtu_pkg::t_flags r3_f;
    logic [LW-1:0]    r3_l0, r3_l1, r3_l2, r3_cr;
    logic [LMW-1:0]   r3_lim1, r3_lim2;
    logic [T2-1:0]    r3_tp2, r3_ts2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_f    <= w3_f;
            r3_l0   <= r2_l0;
            r3_l1   <= r2_l1;
            r3_l2   <= r2_l2;
            r3_cr   <= r2_qa[CW-1] ? LW'(-r2_qa) : LW'(r2_qa);
            r3_lim1 <= LMW'(x_l2) + LMW'(x_tp2);
            r3_lim2 <= LMW'(x_l0) + LMW'(x_tp2);
            r3_tp2  <= r2_tp2;
            r3_ts2  <= r2_ts2;
        end
    end

    // stage 4: ring excess over the limit, operand selection
    logic [LMW:0]   e1, e2;
    logic [T4-1:0]  t4;
    phtu_pkg::t_flags w4_f;

    assign e1 = {1'b0, LMW'(r3_l0)} - {1'b0, r3_lim1};
    assign e2 = {1'b0, LMW'(r3_l2)} - {1'b0, r3_lim2};
    assign t4 = {r3_tp2, 2'b00};

    always_comb begin
        w4_f     = r3_f;
        w4_f.le1 = e1[LMW] || (e1 == '0);
        w4_f.le2 = e2[LMW] || (e2 == '0);
    end

    phtu_pkg::t_flags r4_f, r5_f, r6_f;
    logic [LMW-1:0]   r4_m0a, r4_m2a;
    logic [LW-1:0]    r4_m1a, r4_m3a;
    logic [T4-1:0]    r4_m1b, r4_m3b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_f   <= w4_f;
            r4_m0a <= r3_f.is_segment ? LMW'(r3_cr) : e1[LMW-1:0];
            r4_m1a <= r3_f.is_segment ? r3_l1 : r3_l2;
            r4_m1b <= r3_f.is_segment ? T4'(r3_ts2) : t4;
            r4_m2a <= e2[LMW-1:0];
            r4_m3a <= r3_l0;
            r4_m3b <= t4;
            r5_f   <= r4_f;
            r6_f   <= r5_f;
        end
    end

    // stages 5 and 6: wide products
    logic [P0W-1:0] w_m0, w_m2;
    logic [P1W-1:0] w_m1, w_m3;

    phtu_mul #(.A_BITS(LMW), .B_BITS(LMW)) u_mul0 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r4_m0a), .i_b(r4_m0a), .o_p(w_m0)
    );
    phtu_mul #(.A_BITS(LW), .B_BITS(T4)) u_mul1 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r4_m1a), .i_b(r4_m1b), .o_p(w_m1)
    );
    phtu_mul #(.A_BITS(LMW), .B_BITS(LMW)) u_mul2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r4_m2a), .i_b(r4_m2a), .o_p(w_m2)
    );
    phtu_mul #(.A_BITS(LW), .B_BITS(T4)) u_mul3 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r4_m3a), .i_b(r4_m3b), .o_p(w_m3)
    );

    // output stage: final compares and selection by kind
    logic c01, c23, seg_hit, arc_hit, n_hit;

    assign c01     = PXW'(w_m0) <= PXW'(w_m1);
    assign c23     = PXW'(w_m2) <= PXW'(w_m3);
    assign seg_hit = r6_f.seg_wide ? c01 : r6_f.seg_early;
    assign arc_hit = (r6_f.le1 || c01) && (r6_f.le2 || c23) && r6_f.ang_ok;

    always_comb begin
        n_hit = 1'b0;
        if (r6_f.is_point)   n_hit = r6_f.pt_hit;
        if (r6_f.is_circle)  n_hit = r6_f.circ_hit;
        if (r6_f.is_segment) n_hit = seg_hit;
        if (r6_f.is_arc)     n_hit = arc_hit;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= n_hit;
        end
    end
endmodule
`default_nettype wire

>>> dv/primitive_hit_test_unit_checker.sv
// checker for the primitive hit test unit: predicts every hit flag and compares results
`default_nettype none
module primitive_hit_test_unit_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_idx,
    input  wire logic [22:0]  i_cfg_data,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [215:0] i_s_tdata,
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [7:0]   i_m_tdata,
    output int                o_errors,
    output int                o_pending,
    output int                o_hits,
    output int                o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    logic [22:0] tol_pt;
    logic [22:0] tol_seg;
    logic        hit_queue[$];

    function automatic t_wide len_sq(t_wide dx, t_wide dy);
        return dx * dx + dy * dy;
    endfunction

    // sqrt(a) <= sqrt(b) + t, without roots
    function automatic logic root_close(t_wide a, t_wide b, t_wide t);
        t_wide lim;
        t_wide e;
        lim = b + t * t;
        if (a <= lim) return 1'b1;
        e = a - lim;
        return (e * e) <= (b * 4 * t * t);
    endfunction

    function automatic int half_plane(t_wide x, t_wide y);
        return (y > 0 || (y == 0 && x >= 0)) ? 0 : 1;
    endfunction

    function automatic logic angle_less(t_wide ax, t_wide ay, t_wide bx, t_wide by);
        int ha;
        int hb;
        ha = half_plane(ax, ay);
        hb = half_plane(bx, by);
        if (ha != hb) return ha < hb;
        return (ax * by - ay * bx) > 0;
    endfunction

    function automatic logic segment_hit(t_wide cx, t_wide cy, t_wide sx, t_wide sy,
                                         t_wide ex, t_wide ey, t_wide ts);
        t_wide dx, dy, ux, uy, fx, fy, t2, cr;
        dx = ex - sx; dy = ey - sy;
        ux = cx - sx; uy = cy - sy;
        fx = cx - ex; fy = cy - ey;
        t2 = ts * ts;
        if (dx == 0 && dy == 0) return len_sq(ux, uy) <= t2;
        if (ux * dx + uy * dy <= 0) return len_sq(ux, uy) <= t2;
        if (fx * dx + fy * dy >= 0) return len_sq(fx, fy) <= t2;
        cr = ux * dy - uy * dx;
        if (cr < 0) cr = -cr;
        return (cr * cr) <= len_sq(dx, dy) * t2;
    endfunction

    function automatic logic arc_hit(t_wide cx, t_wide cy, t_wide sx, t_wide sy,
                                     t_wide ex, t_wide ey, t_wide mx, t_wide my,
                                     t_wide tp);
        t_wide rr, dd, ax, ay, bx, by, qx, qy;
        rr = len_sq(sx - mx, sy - my);
        dd = len_sq(cx - mx, cy - my);
        ax = ex - mx; ay = my - ey;
        bx = sx - mx; by = my - sy;
        qx = cx - mx; qy = my - cy;
        if (!root_close(dd, rr, tp) || !root_close(rr, dd, tp)) return 1'b0;
        // a direction of zero length counts as angle zero
        if (ax == 0 && ay == 0) ax = 1;
        if (bx == 0 && by == 0) bx = 1;
        if (qx == 0 && qy == 0) qx = 1;
        if (angle_less(bx, by, ax, ay))
            return !angle_less(qx, qy, ax, ay) || !angle_less(bx, by, qx, qy);
        return !angle_less(qx, qy, ax, ay) && !angle_less(bx, by, qx, qy);
    endfunction

    function automatic logic predict_hit(logic [215:0] d, phtu_pkg::t_action act,
                                         logic [22:0] tp_r, logic [22:0] ts_r);
        t_wide c[8];
        t_wide r, tp, ts, dsq;
        logic h;
        for (int k = 0; k < 8; k++) c[k] = t_wide'($signed(d[24*k +: 24]));
        r  = t_wide'(d[214:192]);
        tp = t_wide'(tp_r);
        ts = t_wide'(ts_r);
        case (act)
            phtu_pkg::ACT_POINT: begin
                h = len_sq(c[0] - c[2], c[1] - c[3]) <= tp * tp;
            end
            phtu_pkg::ACT_CIRCLE: begin
                dsq = len_sq(c[0] - c[2], c[1] - c[3]);
                h = dsq <= (r + tp) * (r + tp);
                if (h && r > tp) h = ((r - tp) * (r - tp)) <= dsq;
            end
            phtu_pkg::ACT_SEGMENT: h = segment_hit(c[0], c[1], c[2], c[3], c[4], c[5], ts);
            default: h = arc_hit(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], tp);
        endcase
        return h;
    endfunction

    assign o_pending = hit_queue.size();

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            tol_pt  <= 23'd768;
            tol_seg <= 23'd1280;
            hit_queue.delete();
            o_errors  <= 0;
            o_hits    <= 0;
            o_results <= 0;
        end else begin
            if (i_cfg_we) begin
                if (phtu_pkg::t_cfg_idx'(i_cfg_idx) == phtu_pkg::CFG_TOL_POINT)
                    tol_pt <= i_cfg_data;
                else
                    tol_seg <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                hit_queue.insert(hit_queue.size(),
                                 predict_hit(i_s_tdata, phtu_pkg::t_action'(i_s_tuser),
                                             tol_pt, tol_seg));
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (i_m_tdata[0]) o_hits <= o_hits + 1;
                if (hit_queue.size() == 0) begin
                    $display("%0t: result with nothing expected, actual hit %0b",
                             $time, i_m_tdata[0]);
                    o_errors <= o_errors + 1;
                end else begin
                    want = hit_queue.pop_front();
                    if (want !== i_m_tdata[0]) begin
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, want, i_m_tdata[0]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> dv/primitive_hit_test_unit_tb.sv
// testbench top of the primitive hit test unit: stimulus, configuration phases and verdict
`default_nettype none
module primitive_hit_test_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        phtu_pkg::t_action act;
        int                c[8];   // cursor x,y, p0 x,y, p1 x,y, p2 x,y
        int                rad;
    } t_hit_item;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_idx = 1'b0;
    logic [22:0]  i_cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [215:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    int           errors, pending, hits, results;
    int           items_sent = 0;
    int           phases_done = 0;
    t_hit_item    dir[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    primitive_hit_test_unit #(.COORD_BITS(24)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    primitive_hit_test_unit_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .o_errors(errors), .o_pending(pending),
        .o_hits(hits), .o_results(results)
    );

    function automatic int spread(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // mostly well-formed primitives around the cursor, some pure noise
    function automatic t_hit_item random_item();
        t_hit_item it;
        int mx, my, dx, dy, k, sc, n, rx, ry;
        it.act = phtu_pkg::t_action'($urandom_range(0, 3));
        it.rad = int'($urandom());
        for (int j = 0; j < 8; j++) it.c[j] = int'($urandom());
        if ($urandom_range(0, 9) == 0) return it;
        sc = 1 << (4 + 4 * $urandom_range(0, 4));
        n  = 1 << $urandom_range(0, 11);
        mx = spread(1 << 22);
        my = spread(1 << 22);
        dx = spread(sc);
        dy = spread(sc);
        case (it.act)
            phtu_pkg::ACT_POINT: begin
                it.c[2] = mx; it.c[3] = my;
                it.c[0] = mx + spread(n); it.c[1] = my + spread(n);
            end
            phtu_pkg::ACT_CIRCLE: begin
                it.c[2] = mx; it.c[3] = my;
                it.c[0] = mx + dx; it.c[1] = my + spread(n);
                it.rad  = (dx < 0 ? -dx : dx) + spread(n);
            end
            phtu_pkg::ACT_SEGMENT: begin
                k = int'($urandom_range(0, 24)) - 4;
                it.c[2] = mx; it.c[3] = my;
                it.c[4] = mx + dx; it.c[5] = my + dy;
                if ($urandom_range(0, 15) == 0) begin
                    it.c[4] = mx; it.c[5] = my;
                end
                it.c[0] = mx + ((dx * k) >>> 4) + spread(n);
                it.c[1] = my + ((dy * k) >>> 4) + spread(n);
            end
            default: begin
                it.c[6] = mx; it.c[7] = my;
                it.c[2] = mx + dx; it.c[3] = my + dy;
                // end and cursor at quarter turns of the start, cursor sometimes skewed
                k = int'($urandom_range(0, 3));
                rx = (k == 0) ? dx : (k == 1) ? -dy : (k == 2) ? -dx : dy;
                ry = (k == 0) ? dy : (k == 1) ? dx : (k == 2) ? -dy : -dx;
                it.c[4] = mx + rx; it.c[5] = my + ry;
                k = int'($urandom_range(0, 3));
                rx = (k == 0) ? dx : (k == 1) ? -dy : (k == 2) ? -dx : dy;
                ry = (k == 0) ? dy : (k == 1) ? dx : (k == 2) ? -dy : -dx;
                if ($urandom_range(0, 1)) begin
                    rx = rx + (ry >>> 2); ry = ry - (rx >>> 2);
                end
                it.c[0] = mx + rx + spread(n); it.c[1] = my + ry + spread(n);
            end
        endcase
        return it;
    endfunction

    function automatic t_hit_item make_item(phtu_pkg::t_action a, int cx, int cy,
                                            int x0, int y0, int x1, int y1,
                                            int x2, int y2, int r);
        t_hit_item it;
        it.act = a;
        it.c[0] = cx; it.c[1] = cy; it.c[2] = x0; it.c[3] = y0;
        it.c[4] = x1; it.c[5] = y1; it.c[6] = x2; it.c[7] = y2;
        it.rad = r;
        return it;
    endfunction

    // append one directed item to the list
    function automatic void add_item(phtu_pkg::t_action a, int cx, int cy,
                                     int x0, int y0, int x1, int y1,
                                     int x2, int y2, int r);
        dir.insert(dir.size(), make_item(a, cx, cy, x0, y0, x1, y1, x2, y2, r));
    endfunction

    task automatic send_item(t_hit_item it, int gap);
        logic [215:0] d;
        d = '0;
        for (int j = 0; j < 8; j++) d[24*j +: 24] = 24'(it.c[j]);
        d[214:192] = 23'(it.rad);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= it.act;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    function automatic int sender_gap();
        // every third stretch of 64 items runs back to back
        if ((items_sent / 64) % 3 == 0) return 0;
        return int'($urandom_range(0, 17));
    endfunction

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the checker see the last accepted item first
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_tolerances(logic [22:0] tp, logic [22:0] ts);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= phtu_pkg::CFG_TOL_POINT;
        i_cfg_data <= tp;
        @(posedge i_clk);
        i_cfg_idx  <= phtu_pkg::CFG_TOL_SEGMENT;
        i_cfg_data <= ts;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        phases_done++;
    endtask

    // receiver with random stalls and one long hold-off
    initial begin
        int n;
        int held;
        held = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results >= 300) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            n = ((results / 80) % 3 == 1) ? 0 : int'($urandom_range(0, 17));
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        #20ms;
        $display("primitive_hit_test_unit_tb NOT OK");
        $finish;
    end

    initial begin
        localparam int MX = 8388607;
        localparam int MN = -8388608;
        logic [22:0] tps[6];
        logic [22:0] tss[6];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_tolerances(23'd768, 23'd1280);
        // point: exact, on the tolerance, just outside, far corners
        add_item(phtu_pkg::ACT_POINT, 100, 100, 100, 100, 0, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_POINT, 868, 0, 100, 0, MX, MN, MX, MN, MX);
        add_item(phtu_pkg::ACT_POINT, 869, 0, 100, 0, 0, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_POINT, MX, MX, MN, MN, MN, MN, MN, MN, 0);
        add_item(phtu_pkg::ACT_POINT, MN, MN, MN, MN, MX, MX, MX, MX, MX);
        // circle: radius zero, radius below and above tolerance, rim edges
        add_item(phtu_pkg::ACT_CIRCLE, 500, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 500);
        add_item(phtu_pkg::ACT_CIRCLE, 10768, 0, 0, 0, 0, 0, 0, 0, 10000);
        add_item(phtu_pkg::ACT_CIRCLE, 9232, 0, 0, 0, 0, 0, 0, 0, 10000);
        add_item(phtu_pkg::ACT_CIRCLE, 9231, 0, 0, 0, 0, 0, 0, 0, 10000);
        add_item(phtu_pkg::ACT_CIRCLE, MX, MX, MN, MN, 0, 0, 0, 0, MX);
        // segment: zero length, before start, past end, middle, extremes
        add_item(phtu_pkg::ACT_SEGMENT, 1280, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_SEGMENT, -1000, 500, 0, 0, 5000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_SEGMENT, 6000, 0, 0, 0, 5000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_SEGMENT, 2500, 1280, 0, 0, 5000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_SEGMENT, 2500, 1281, 0, 0, 5000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_SEGMENT, 0, 0, MN, MN, MX, MX, 0, 0, 0);
        // arc: quarter sweep in and out, wrap through zero, equal ends,
        // start on the center, cursor on the center
        add_item(phtu_pkg::ACT_ARC, 707, -707, 1000, 0, 0, -1000, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, -707, 707, 1000, 0, 0, -1000, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, 1000, 0, 0, -1000, 0, 1000, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, -1000, 0, 0, -1000, 0, 1000, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, 1000, 0, 1000, 0, 1000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, 0, -1000, 1000, 0, 1000, 0, 0, 0, 0);
        add_item(phtu_pkg::ACT_ARC, 5, 5, 5, 5, 5, 5, 5, 5, 0);
        add_item(phtu_pkg::ACT_ARC, 0, 0, 500, 0, 0, 500, 0, 0, 0);
        foreach (dir[j]) send_item(dir[j], int'($urandom_range(0, 3)));
        wait_idle();

        // tolerance settings: extremes, defaults, random
        tps[0] = 23'd0;       tss[0] = 23'd0;
        tps[1] = 23'h7fffff;  tss[1] = 23'h7fffff;
        tps[2] = 23'd768;     tss[2] = 23'd1280;
        tps[3] = 23'd1;       tss[3] = 23'h7fffff;
        tps[4] = 23'($urandom_range(0, 1 << 16));
        tss[4] = 23'($urandom_range(0, 1 << 16));
        tps[5] = 23'($urandom());
        tss[5] = 23'($urandom_range(0, 1 << 12));
        for (int p = 0; p < 6; p++) begin
            set_tolerances(tps[p], tss[p]);
            // the phases after the two extreme ones carry most of the items
            repeat ((p == 0 || p == 1) ? 60 : 250) send_item(random_item(), sender_gap());
            wait_idle();
        end

        $display("sent %0d items over %0d tolerance settings, %0d results with %0d hits",
                 items_sent, phases_done, results, hits);
        if (errors == 0)
            $display("primitive_hit_test_unit_tb OK");
        else
            $display("primitive_hit_test_unit_tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
